// ----- hw/rtl/pslt_pkg.sv -----
// ----------------------------------------------------------------------------
// pslt_pkg
// Shared widths, register codes and table entry types for the per-sensor
// frame loss tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pslt_pkg;

    localparam int SENSORS   = 64;
    localparam int ID_W      = 6;
    localparam int SEQ_W     = 32;
    localparam int PBYTES_W  = 16;
    localparam int PKT_W     = 8;
    localparam int SBYTES_W  = 40;
    localparam int LOST_W    = 32;
    localparam int TOTAL_W   = 48;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [PKT_W-1:0] FRAME_PACKETS_RST = PKT_W'(4);
    localparam logic [PKT_W-1:0] PKT_MAX           = '1;

    typedef enum logic [0:0] {
        REG_FRAME_PACKETS = 1'b0
    } t_reg_idx;

    typedef struct packed {
        logic [SEQ_W-1:0]    cur_frame;
        logic [PKT_W-1:0]    pkts_seen;
        logic [SBYTES_W-1:0] sbytes;
    } t_entry;

    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] id;
        t_entry          entry;
    } t_tbl_wr;

endpackage

`default_nettype wire

// ----- hw/rtl/pslt_cfg.sv -----
// ----------------------------------------------------------------------------
// pslt_cfg
// APB register file holding the packets-per-frame setting.
// ----------------------------------------------------------------------------
`default_nettype none

module pslt_cfg import pslt_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    output logic [PKT_W-1:0]        o_frame_packets
);

    logic [PKT_W-1:0] r_frame_packets;
    t_reg_idx         reg_idx;
    logic             wr_beat;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1]);
    assign wr_beat = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_packets <= FRAME_PACKETS_RST;
        end else if (wr_beat) begin
            case (reg_idx)
                REG_FRAME_PACKETS: r_frame_packets <= pwdata[PKT_W-1:0];
                default:           r_frame_packets <= r_frame_packets;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_PACKETS: prdata = PDATA_W'(r_frame_packets);
            default:           prdata = '0;
        endcase
    end

    assign o_frame_packets = r_frame_packets;

endmodule

`default_nettype wire

// ----- hw/rtl/pslt_table.sv -----
// ----------------------------------------------------------------------------
// pslt_table
// Per-sensor state memory with reset valid bits and write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module pslt_table import pslt_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_rd_en,
    input  wire logic [ID_W-1:0] i_rd_id,
    input  wire t_tbl_wr         i_wr,
    output t_entry               o_entry
);

    t_entry               mem [SENSORS];
    logic [SENSORS-1:0]   r_valid;
    t_entry               r_rd_q;
    t_entry               r_fwd;
    logic                 r_rd_vld;
    logic                 r_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.id] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_q <= mem[i_rd_id];
            r_fwd  <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.id] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_id];
                // the entry being written this edge is newer than the array
                r_hit    <= i_wr.en && (i_wr.id == i_rd_id);
            end
        end
    end

    assign o_entry = r_hit ? r_fwd : (r_rd_vld ? r_rd_q : '0);

endmodule

`default_nettype wire

// ----- hw/rtl/pslt_update.sv -----
// ----------------------------------------------------------------------------
// pslt_update
// Frame tracking update, saturating counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pslt_update import pslt_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_vld,
    input  wire logic [ID_W-1:0]     i_id,
    input  wire logic [SEQ_W-1:0]    i_seq,
    input  wire logic [PBYTES_W-1:0] i_pbytes,
    input  wire t_entry              i_entry,
    input  wire logic [PKT_W-1:0]    i_frame_packets,
    output t_tbl_wr                  o_wr,
    output logic                     o_valid,
    output logic                     o_is_registration,
    output logic                     o_seq_backwards,
    output logic                     o_frame_lost,
    output logic [PKT_W-1:0]         o_missing_packets,
    output logic                     o_frame_complete,
    output logic [SBYTES_W-1:0]      o_sensor_bytes,
    output logic [LOST_W-1:0]        o_lost_frames_total,
    output logic [LOST_W-1:0]        o_lost_packets_total,
    output logic [TOTAL_W-1:0]       o_bytes_total
);

    logic [LOST_W-1:0]   r_lost_frames, n_lost_frames;
    logic [LOST_W-1:0]   r_lost_pkts,   n_lost_pkts;
    logic [TOTAL_W-1:0]  r_bytes_total, n_bytes_total;

    logic                r_valid;
    logic                r_is_reg;
    logic                r_back;
    logic                r_lost;
    logic [PKT_W-1:0]    r_missing;
    logic                r_done;
    logic [SBYTES_W-1:0] r_sbytes;

    logic                is_reg;
    logic                back;
    logic                lost;
    logic                done;
    logic [PKT_W-1:0]    missing;
    logic [PKT_W-1:0]    pkts_inc;
    t_entry              new_entry;
    logic [SBYTES_W:0]   sb_sum;
    logic [SBYTES_W-1:0] sb_new;
    logic [TOTAL_W:0]    tot_sum;
    logic [LOST_W:0]     lf_sum;
    logic [LOST_W:0]     lp_sum;

    // saturating sums: a carry out pins the counter at its top
    assign sb_sum   = {1'b0, i_entry.sbytes} + (SBYTES_W+1)'(i_pbytes);
    assign sb_new   = sb_sum[SBYTES_W] ? '1 : sb_sum[SBYTES_W-1:0];
    assign tot_sum  = {1'b0, r_bytes_total} + (TOTAL_W+1)'(i_pbytes);
    assign lf_sum   = {1'b0, r_lost_frames} + (LOST_W+1)'(1);
    assign lp_sum   = {1'b0, r_lost_pkts} + (LOST_W+1)'(missing);
    assign pkts_inc = i_entry.pkts_seen + PKT_W'(1);

    always_comb begin
        is_reg    = (i_seq == '0);
        back      = 1'b0;
        lost      = 1'b0;
        missing   = '0;
        done      = 1'b0;
        new_entry = i_entry;
        if (!is_reg) begin
            new_entry.sbytes = sb_new;
            if (i_seq != i_entry.cur_frame) begin
                // a stored frame of zero means no numbered packet yet
                if (i_entry.cur_frame != '0) begin
                    back = (i_seq < i_entry.cur_frame);
                    if (i_entry.pkts_seen < i_frame_packets) begin
                        lost    = 1'b1;
                        missing = i_frame_packets - i_entry.pkts_seen;
                    end
                end
                new_entry.cur_frame = i_seq;
                new_entry.pkts_seen = PKT_W'(1);
                done                = (i_frame_packets == PKT_W'(1));
            end else if (i_entry.pkts_seen != PKT_MAX) begin
                new_entry.pkts_seen = pkts_inc;
                done                = (pkts_inc == i_frame_packets);
            end
        end
    end

    always_comb begin
        o_wr.en       = i_vld && !is_reg;
        o_wr.id       = i_id;
        o_wr.entry    = new_entry;
        n_bytes_total = r_bytes_total;
        n_lost_frames = r_lost_frames;
        n_lost_pkts   = r_lost_pkts;
        if (i_vld) begin
            n_bytes_total = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
            if (lost) begin
                n_lost_frames = lf_sum[LOST_W] ? '1 : lf_sum[LOST_W-1:0];
                n_lost_pkts   = lp_sum[LOST_W] ? '1 : lp_sum[LOST_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lost_frames <= '0;
            r_lost_pkts   <= '0;
            r_bytes_total <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_lost_frames <= n_lost_frames;
            r_lost_pkts   <= n_lost_pkts;
            r_bytes_total <= n_bytes_total;
            r_valid       <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_is_reg  <= is_reg;
            r_back    <= back;
            r_lost    <= lost;
            r_missing <= missing;
            r_done    <= done;
            r_sbytes  <= new_entry.sbytes;
        end
    end

    assign o_valid              = r_valid;
    assign o_is_registration    = r_is_reg;
    assign o_seq_backwards      = r_back;
    assign o_frame_lost         = r_lost;
    assign o_missing_packets    = r_missing;
    assign o_frame_complete     = r_done;
    assign o_sensor_bytes       = r_sbytes;
    assign o_lost_frames_total  = r_lost_frames;
    assign o_lost_packets_total = r_lost_pkts;
    assign o_bytes_total        = r_bytes_total;

    a_lost_has_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_lost) |-> (r_missing != '0))
        else $error("lost frame reported with no missing packets");

    a_reg_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_is_reg) |-> (!r_lost && !r_done && !r_back))
        else $error("registration beat carries frame flags");

    a_lost_frames_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_lost_frames >= $past(r_lost_frames)))
        else $error("lost frame total decreased");

    a_lost_pkts_moves_with_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_lost_pkts != $past(r_lost_pkts)))
            |-> $past(i_vld && lost))
        else $error("lost packet total moved without a lost frame");

endmodule

`default_nettype wire

// ----- hw/rtl/per_sensor_frame_loss_tracker.sv -----
// A result strobe on o_valid follows the start beat through the r_s1 stage and the update result register.
// Throughput: one packet header per cycle; busy stays low, since the table
// read-modify-write of back-to-back beats to one sensor is forwarded.
// Each start beat gives exactly one result beat; the receiver cannot stall.
// Reset clears the sensor table valid bits and all totals;
// packets per frame returns to 4.
// ----------------------------------------------------------------------------
// per_sensor_frame_loss_tracker
// Per-sensor frame sequence tracking with lost frame and packet accounting.
// ----------------------------------------------------------------------------
`default_nettype none

module per_sensor_frame_loss_tracker import pslt_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [ID_W-1:0]     i_sensor_id,
    input  wire logic [SEQ_W-1:0]    i_seq_num,
    input  wire logic [PBYTES_W-1:0] i_packet_bytes,
    output logic                     o_valid,
    output logic                     o_is_registration,
    output logic                     o_seq_backwards,
    output logic                     o_frame_lost,
    output logic [PKT_W-1:0]         o_missing_packets,
    output logic                     o_frame_complete,
    output logic [SBYTES_W-1:0]      o_sensor_bytes,
    output logic [LOST_W-1:0]        o_lost_frames_total,
    output logic [LOST_W-1:0]        o_lost_packets_total,
    output logic [TOTAL_W-1:0]       o_bytes_total,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    logic                accept;
    logic                r_s1_vld;
    logic [ID_W-1:0]     r_s1_id;
    logic [SEQ_W-1:0]    r_s1_seq;
    logic [PBYTES_W-1:0] r_s1_pbytes;
    logic [PKT_W-1:0]    frame_packets;
    t_entry              rd_entry;
    t_tbl_wr             tbl_wr;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_id     <= i_sensor_id;
            r_s1_seq    <= i_seq_num;
            r_s1_pbytes <= i_packet_bytes;
        end
    end

    pslt_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_frame_packets (frame_packets)
    );

    pslt_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_rd_id (i_sensor_id),
        .i_wr    (tbl_wr),
        .o_entry (rd_entry)
    );

    pslt_update u_update (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_vld                (r_s1_vld),
        .i_id                 (r_s1_id),
        .i_seq                (r_s1_seq),
        .i_pbytes             (r_s1_pbytes),
        .i_entry              (rd_entry),
        .i_frame_packets      (frame_packets),
        .o_wr                 (tbl_wr),
        .o_valid              (o_valid),
        .o_is_registration    (o_is_registration),
        .o_seq_backwards      (o_seq_backwards),
        .o_frame_lost         (o_frame_lost),
        .o_missing_packets    (o_missing_packets),
        .o_frame_complete     (o_frame_complete),
        .o_sensor_bytes       (o_sensor_bytes),
        .o_lost_frames_total  (o_lost_frames_total),
        .o_lost_packets_total (o_lost_packets_total),
        .o_bytes_total        (o_bytes_total)
    );

    a_result_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 2))
        else $error("result beat without a start beat two cycles earlier");

    a_start_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && $past(i_rst_n)) |=> ##1 o_valid)
        else $error("start beat produced no result beat");

endmodule

`default_nettype wire
